>>> rtl/core/byte_range_header_parser_top_defines.svh
`ifndef BYTE_RANGE_HEADER_PARSER_TOP_DEFINES_SVH
`define BYTE_RANGE_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define BRHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define BRHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/brhp_pkg.sv
`timescale 1ns / 1ps

package brhp_pkg;

    localparam int ChW      = 8;
    localparam int AccW     = 64;
    localparam int StatusW  = 3;
    localparam int OutDataW = 136;

    localparam logic [2:0] PREFIX_LAST = 3'd5;

    localparam logic [ChW-1:0] CH_NUL   = 8'h00;
    localparam logic [ChW-1:0] CH_TAB   = 8'h09;
    localparam logic [ChW-1:0] CH_CR    = 8'h0d;
    localparam logic [ChW-1:0] CH_SPACE = 8'h20;
    localparam logic [ChW-1:0] CH_PLUS  = 8'h2b;
    localparam logic [ChW-1:0] CH_MINUS = 8'h2d;
    localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
    localparam logic [ChW-1:0] CH_NINE  = 8'h39;

    localparam logic [AccW-1:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [AccW-1:0] NEG_MAG  = 64'h8000_0000_0000_0000;
    localparam logic [AccW-1:0] OPEN_END = 64'h7FFF_FFFF_FFFF_FFFE;

    // largest accumulator that still takes one more digit
    localparam logic [AccW-1:0] THR_HI = 64'd922337203685477580;
    localparam logic [AccW-1:0] THR_LO = 64'd922337203685477579;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_BLANK  = 3'd1,
        PH_BODY   = 3'd2,
        PH_ENDED  = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 3'd0,
        ST_NOTBYTES = 3'd1,
        ST_SUFFIX   = 3'd2,
        ST_NONUM    = 3'd3,
        ST_NODASH   = 3'd4,
        ST_BADFIRST = 3'd5,
        ST_ORDER    = 3'd6
    } t_status;

    typedef struct packed {
        logic [AccW-1:0] acc;
        logic            neg;
        logic            started;
        logic            digits;
        logic            done;
        logic            sat;
    } t_num;

    localparam t_num NUM_CLEAR = '0;

    typedef struct packed {
        t_phase  phase;
        t_status early;
        logic    dash;
        t_num    first;
        t_num    last;
    } t_snap;

    function automatic logic [ChW-1:0] prefix_char(input logic [2:0] pos);
        logic [ChW-1:0] c;
        unique case (pos)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3d;
            3'd6:    c = 8'h62;
            default: c = 8'h79;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [ChW-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [AccW-1:0] sat_limit(input logic neg, input logic [3:0] d);
        logic [AccW-1:0] thr;
        if (neg) begin
            thr = (d <= 4'd8) ? THR_HI : THR_LO;
        end else begin
            thr = (d <= 4'd7) ? THR_HI : THR_LO;
        end
        return thr;
    endfunction

endpackage

>>> rtl/core/brhp_num_feed.sv
`timescale 1ns / 1ps

module brhp_num_feed (
    input  brhp_pkg::t_num                 i_num,
    input  logic [brhp_pkg::ChW-1:0]       i_ch,
    output brhp_pkg::t_num                 o_num
);

    logic [3:0]                  digit;
    logic                        is_digit;
    logic                        is_sign;
    logic [brhp_pkg::AccW-1:0]   prod;
    logic [brhp_pkg::AccW-1:0]   thr;

    assign digit    = i_ch[3:0];
    assign is_digit = (i_ch >= brhp_pkg::CH_ZERO) && (i_ch <= brhp_pkg::CH_NINE);
    assign is_sign  = (i_ch == brhp_pkg::CH_PLUS) || (i_ch == brhp_pkg::CH_MINUS);
    assign thr      = brhp_pkg::sat_limit(i_num.neg, digit);
    // acc * 10 + digit as two shifts and two adds
    assign prod     = {i_num.acc[brhp_pkg::AccW-4:0], 3'b000}
                    + {i_num.acc[brhp_pkg::AccW-2:0], 1'b0}
                    + {{(brhp_pkg::AccW-4){1'b0}}, digit};

    always_comb begin
        o_num = i_num;
        priority if (i_num.done) begin
        end else if (!i_num.started && brhp_pkg::is_space(i_ch)) begin
        end else if (!i_num.started && is_sign) begin
            o_num.started = 1'b1;
            o_num.neg     = (i_ch == brhp_pkg::CH_MINUS);
        end else begin
            o_num.started = 1'b1;
            if (!is_digit) begin
                o_num.done = 1'b1;
            end else begin
                o_num.digits = 1'b1;
                if (!i_num.sat) begin
                    if (i_num.acc > thr) begin
                        o_num.sat = 1'b1;
                        o_num.acc = i_num.neg ? brhp_pkg::NEG_MAG : brhp_pkg::POS_MAX;
                    end else begin
                        o_num.acc = prod;
                    end
                end
            end
        end
    end

endmodule

>>> rtl/core/byte_range_header_parser_top.sv
`timescale 1ns / 1ps

// channel   | dir | tdata (lsb first)                               | tlast
// ----------+-----+-------------------------------------------------+-----------
// s (chars) | in  | ch[7:0]                                         | final_char
// m (range) | out | status[2:0], range_begin[66:3], range_end[130:67] | unused
//
// one character per cycle unless output back-pressure holds a final character;
// the 64-bit multiply-by-ten accumulate in the header state loop sets that figure
// a result passes the snapshot, value and output registers after its final character
// synchronous active-low reset clears the header state and all valid flags
// output back-pressure fills three result stages before the final character
// of the next header waits; other characters keep flowing

module byte_range_header_parser_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // ch
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [brhp_pkg::OutDataW-1:0]      o_m_tdata    // status, range_begin, range_end
);

    // input register
    logic                          r_in_vld;
    logic [brhp_pkg::ChW-1:0]      r_ch;
    logic                          r_in_last;

    // header state
    logic [2:0]                    r_prefix_pos, n_prefix_pos;
    brhp_pkg::t_phase              r_phase, n_phase;
    brhp_pkg::t_status             r_early, n_early;
    brhp_pkg::t_num                r_first, n_first;
    logic                          r_dash, n_dash;
    brhp_pkg::t_num                r_last, n_last;
    brhp_pkg::t_num                first_fed;
    brhp_pkg::t_num                last_fed;
    logic                          body;

    // result stages
    logic                          r_s_vld;
    brhp_pkg::t_snap               r_s;
    logic                          r_v_vld;
    brhp_pkg::t_status             r_v_status, n_v_status;
    logic                          r_v_cmp, n_v_cmp;
    logic [brhp_pkg::AccW-1:0]     r_v_front, n_v_front;
    logic [brhp_pkg::AccW-1:0]     r_v_back, n_v_back;
    logic                          r_o_vld;
    brhp_pkg::t_status             r_o_status, n_o_status;
    logic [brhp_pkg::AccW-1:0]     r_o_beg, n_o_beg;
    logic [brhp_pkg::AccW-1:0]     r_o_end, n_o_end;

    logic                          o_ready;
    logic                          v_ready;
    logic                          s_ready;
    logic                          b_fire;

    assign o_ready    = !r_o_vld || i_m_tready;
    assign v_ready    = !r_v_vld || o_ready;
    assign s_ready    = !r_s_vld || v_ready;
    assign b_fire     = r_in_vld && (!r_in_last || s_ready);
    assign o_s_tready = !r_in_vld || b_fire;

    brhp_num_feed u_first_feed (
        .i_num (r_first),
        .i_ch  (r_ch),
        .o_num (first_fed)
    );

    brhp_num_feed u_last_feed (
        .i_num (r_last),
        .i_ch  (r_ch),
        .o_num (last_fed)
    );

    always_comb begin
        n_prefix_pos = r_prefix_pos;
        n_phase      = r_phase;
        n_early      = r_early;
        n_first      = r_first;
        n_dash       = r_dash;
        n_last       = r_last;
        body         = 1'b0;
        unique case (r_phase)
            brhp_pkg::PH_PREFIX: begin
                if (r_ch != brhp_pkg::prefix_char(r_prefix_pos)) begin
                    n_early = brhp_pkg::ST_NOTBYTES;
                    n_phase = brhp_pkg::PH_DONE;
                end else begin
                    n_prefix_pos = r_prefix_pos + 3'd1;
                    if (r_prefix_pos >= brhp_pkg::PREFIX_LAST) begin
                        n_phase = brhp_pkg::PH_BLANK;
                    end
                end
            end
            brhp_pkg::PH_BLANK: begin
                priority if (r_ch == brhp_pkg::CH_SPACE || r_ch == brhp_pkg::CH_TAB) begin
                end else if (r_ch == brhp_pkg::CH_NUL) begin
                    n_early = brhp_pkg::ST_NONUM;
                    n_phase = brhp_pkg::PH_DONE;
                end else if (r_ch == brhp_pkg::CH_MINUS) begin
                    n_early = brhp_pkg::ST_SUFFIX;
                    n_phase = brhp_pkg::PH_DONE;
                end else begin
                    n_phase = brhp_pkg::PH_BODY;
                    body    = 1'b1;
                end
            end
            brhp_pkg::PH_BODY: begin
                if (r_ch == brhp_pkg::CH_NUL) begin
                    n_phase = brhp_pkg::PH_ENDED;
                end else begin
                    body = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (body) begin
            n_first = first_fed;
            if (r_dash) begin
                n_last = last_fed;
            end else if (r_ch == brhp_pkg::CH_MINUS) begin
                n_dash = 1'b1;
            end
        end
    end

    // status precedence and signed values
    always_comb begin
        n_v_cmp = 1'b0;
        priority if (r_s.phase == brhp_pkg::PH_DONE) begin
            n_v_status = r_s.early;
        end else if (r_s.phase == brhp_pkg::PH_PREFIX) begin
            n_v_status = brhp_pkg::ST_NOTBYTES;
        end else if (r_s.phase == brhp_pkg::PH_BLANK) begin
            n_v_status = brhp_pkg::ST_NONUM;
        end else if (!r_s.dash) begin
            n_v_status = brhp_pkg::ST_NODASH;
        end else if (!r_s.first.digits) begin
            n_v_status = brhp_pkg::ST_BADFIRST;
        end else begin
            n_v_status = brhp_pkg::ST_OK;
            n_v_cmp    = 1'b1;
        end
        n_v_front = r_s.first.neg ? (64'd0 - r_s.first.acc) : r_s.first.acc;
        if (!r_s.last.digits) begin
            n_v_back = brhp_pkg::OPEN_END;
        end else begin
            n_v_back = r_s.last.neg ? (64'd0 - r_s.last.acc) : r_s.last.acc;
        end
    end

    // order check and exclusive end
    always_comb begin
        n_o_status = r_v_status;
        n_o_beg    = '0;
        n_o_end    = '0;
        if (r_v_cmp) begin
            if ($signed(r_v_front) > $signed(r_v_back)) begin
                n_o_status = brhp_pkg::ST_ORDER;
            end else begin
                n_o_status = brhp_pkg::ST_OK;
                n_o_beg    = r_v_front;
                n_o_end    = (r_v_back == brhp_pkg::POS_MAX) ? brhp_pkg::POS_MAX
                                                            : r_v_back + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_s_vld      <= 1'b0;
            r_v_vld      <= 1'b0;
            r_o_vld      <= 1'b0;
            r_prefix_pos <= '0;
            r_phase      <= brhp_pkg::PH_PREFIX;
            r_early      <= brhp_pkg::ST_OK;
            r_first      <= brhp_pkg::NUM_CLEAR;
            r_dash       <= 1'b0;
            r_last       <= brhp_pkg::NUM_CLEAR;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (b_fire) begin
                if (r_in_last) begin
                    r_prefix_pos <= '0;
                    r_phase      <= brhp_pkg::PH_PREFIX;
                    r_early      <= brhp_pkg::ST_OK;
                    r_first      <= brhp_pkg::NUM_CLEAR;
                    r_dash       <= 1'b0;
                    r_last       <= brhp_pkg::NUM_CLEAR;
                end else begin
                    r_prefix_pos <= n_prefix_pos;
                    r_phase      <= n_phase;
                    r_early      <= n_early;
                    r_first      <= n_first;
                    r_dash       <= n_dash;
                    r_last       <= n_last;
                end
            end
            if (s_ready) begin
                r_s_vld <= b_fire && r_in_last;
            end
            if (v_ready) begin
                r_v_vld <= r_s_vld;
            end
            if (o_ready) begin
                r_o_vld <= r_v_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_ch      <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (s_ready) begin
            r_s.phase <= n_phase;
            r_s.early <= n_early;
            r_s.dash  <= n_dash;
            r_s.first <= n_first;
            r_s.last  <= n_last;
        end
        if (v_ready) begin
            r_v_status <= n_v_status;
            r_v_cmp    <= n_v_cmp;
            r_v_front  <= n_v_front;
            r_v_back   <= n_v_back;
        end
        if (o_ready) begin
            r_o_status <= n_o_status;
            r_o_beg    <= n_o_beg;
            r_o_end    <= n_o_end;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {5'b00000, r_o_end, r_o_beg, r_o_status};

endmodule

>>> rtl/core/brhp_checker.sv
`timescale 1ns / 1ps

`include "byte_range_header_parser_top_defines.svh"

module brhp_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,
    input  logic                               i_s_tlast,
    input  logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [brhp_pkg::OutDataW-1:0]      o_m_tdata
);

    logic [brhp_pkg::StatusW-1:0]  status;
    logic [brhp_pkg::AccW-1:0]     beg_w;
    logic [brhp_pkg::AccW-1:0]     end_w;
    logic                          s_xfer;

    assign status = o_m_tdata[2:0];
    assign beg_w  = o_m_tdata[66:3];
    assign end_w  = o_m_tdata[130:67];
    assign s_xfer = i_s_tvalid && o_s_tready && (i_s_tdata != 8'h00 || i_s_tlast);

    `BRHP_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")
    `BRHP_ASSERT_SAME(a_err_zero, o_m_tvalid && status != brhp_pkg::ST_OK, beg_w == 64'd0 && end_w == 64'd0, "error result carries a range")
    `BRHP_ASSERT_SAME(a_order, o_m_tvalid && status == brhp_pkg::ST_OK, $signed(beg_w) <= $signed(end_w), "range begin above end")
    `BRHP_ASSERT_SAME(a_code, o_m_tvalid, status <= brhp_pkg::ST_ORDER && !o_m_tdata[135], "bad status code")
    `BRHP_ASSERT_SAME(a_pad, s_xfer || !s_xfer, o_m_tdata[135:131] == 5'd0, "padding bits set")

endmodule

bind byte_range_header_parser_top brhp_checker u_brhp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> verif/byte_range_header_parser_top_tb.sv
`timescale 1ns / 1ps

module byte_range_header_parser_top_tb;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          CHAR_TARGET = 1250;
    localparam int          HOLD_CYCLES = 600;
    localparam logic [63:0] MAX_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_NEG_MAG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] OPEN_LAST   = 64'h7FFF_FFFF_FFFF_FFFE;
    localparam logic [47:0] UNIT_TAG    = "bytes=";

    typedef struct {
        logic [63:0] acc;
        logic        neg;
        logic        started;
        logic        digits;
        logic        done;
        logic        sat;
    } t_dec;

    typedef struct {
        brhp_pkg::t_status status;
        logic [63:0]       first;
        logic [63:0]       stop;
    } t_range;

    class range_scoreboard;
        logic [2:0]        tag_pos;
        brhp_pkg::t_phase  phase;
        brhp_pkg::t_status early;
        t_dec              first_num;
        t_dec              last_num;
        logic              dash;
        t_range            range_q[$];
        int                fails;

        function new();
            fails = 0;
            clear_header();
        endfunction

        function void clear_header();
            tag_pos   = '0;
            phase     = brhp_pkg::PH_PREFIX;
            early     = brhp_pkg::ST_OK;
            first_num = '{default: '0};
            last_num  = '{default: '0};
            dash      = 1'b0;
        endfunction

        function logic blank(logic [7:0] c);
            return (c == " ") || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function t_dec feed(t_dec p, logic [7:0] c);
            logic [63:0] lim;
            logic [63:0] d;
            if (p.done) return p;
            if (!p.started) begin
                if (blank(c)) return p;
                p.started = 1'b1;
                if (c == "+" || c == "-") begin
                    p.neg = (c == "-");
                    return p;
                end
            end
            if (c < "0" || c > "9") begin
                p.done = 1'b1;
                return p;
            end
            p.digits = 1'b1;
            if (p.sat) return p;
            lim = p.neg ? MAX_NEG_MAG : MAX_POS;
            d = 64'(c - 8'h30);
            if (p.acc > (lim - d) / 64'd10) begin
                p.sat = 1'b1;
                p.acc = lim;
            end else begin
                p.acc = p.acc * 64'd10 + d;
            end
            return p;
        endfunction

        function void body_char(logic [7:0] c);
            first_num = feed(first_num, c);
            if (dash) begin
                last_num = feed(last_num, c);
            end else if (c == "-") begin
                dash = 1'b1;
            end
        endfunction

        function void take_char(logic [7:0] c);
            case (phase)
                brhp_pkg::PH_PREFIX: begin
                    if (c != UNIT_TAG[47 - 8 * tag_pos -: 8]) begin
                        early = brhp_pkg::ST_NOTBYTES;
                        phase = brhp_pkg::PH_DONE;
                    end else begin
                        tag_pos = tag_pos + 3'd1;
                        if (tag_pos >= 3'd6) phase = brhp_pkg::PH_BLANK;
                    end
                end
                brhp_pkg::PH_BLANK: begin
                    if (c == " " || c == 8'h09) begin
                    end else if (c == 8'h00) begin
                        early = brhp_pkg::ST_NONUM;
                        phase = brhp_pkg::PH_DONE;
                    end else if (c == "-") begin
                        early = brhp_pkg::ST_SUFFIX;
                        phase = brhp_pkg::PH_DONE;
                    end else begin
                        phase = brhp_pkg::PH_BODY;
                        body_char(c);
                    end
                end
                brhp_pkg::PH_BODY: begin
                    if (c == 8'h00) phase = brhp_pkg::PH_ENDED;
                    else body_char(c);
                end
                default: begin
                end
            endcase
        endfunction

        function t_range resolve();
            t_range      r;
            logic [63:0] front;
            logic [63:0] back;
            r = '{status: brhp_pkg::ST_OK, first: '0, stop: '0};
            if (phase == brhp_pkg::PH_DONE) begin
                r.status = early;
            end else if (phase == brhp_pkg::PH_PREFIX) begin
                r.status = brhp_pkg::ST_NOTBYTES;
            end else if (phase == brhp_pkg::PH_BLANK) begin
                r.status = brhp_pkg::ST_NONUM;
            end else if (!dash) begin
                r.status = brhp_pkg::ST_NODASH;
            end else if (!first_num.digits) begin
                r.status = brhp_pkg::ST_BADFIRST;
            end else begin
                front = first_num.neg ? -first_num.acc : first_num.acc;
                if (last_num.digits) back = last_num.neg ? -last_num.acc : last_num.acc;
                else back = OPEN_LAST;
                if ($signed(front) > $signed(back)) begin
                    r.status = brhp_pkg::ST_ORDER;
                end else begin
                    r.first = front;
                    r.stop  = (back == MAX_POS) ? MAX_POS : back + 64'd1;
                end
            end
            return r;
        endfunction

        function void note_input(logic [7:0] c, logic fin);
            take_char(c);
            if (fin) begin
                range_q.push_back(resolve());
                clear_header();
            end
        endfunction

        function void check_result(logic [brhp_pkg::OutDataW-1:0] d);
            t_range r;
            if (range_q.size() == 0) begin
                $error("unexpected range transfer, tdata %h", d);
                fails++;
                return;
            end
            r = range_q.pop_front();
            if (d[2:0] != r.status) begin
                $error("status expected %0d actual %0d", r.status, d[2:0]);
                fails++;
            end
            if (d[66:3] != r.first) begin
                $error("range_begin expected %0d actual %0d", $signed(r.first),
                       $signed(d[66:3]));
                fails++;
            end
            if (d[130:67] != r.stop) begin
                $error("range_end expected %0d actual %0d", $signed(r.stop),
                       $signed(d[130:67]));
                fails++;
            end
        endfunction
    endclass

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata  = '0;  // ch
    logic                          i_s_tlast  = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [brhp_pkg::OutDataW-1:0] o_m_tdata;        // status, range_begin, range_end

    range_scoreboard sb = new();
    logic [7:0]      hdr[$];
    int              chars_sent = 0;
    int              cycle_count = 0;
    bit              press_hold = 1'b0;

    byte_range_header_parser_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    task automatic send_char(logic [7:0] c, logic fin, int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(c, fin);
        chars_sent++;
    endtask

    task automatic send_header();
        int mode;
        int gap;
        mode = $urandom_range(0, 2);
        if (hdr.size() == 0) hdr.push_back(8'($urandom_range(0, 255)));
        foreach (hdr[i]) begin
            if (press_hold || mode == 0) gap = 0;
            else if (mode == 1) gap = $urandom_range(0, 18);
            else gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
            send_char(hdr[i], i == hdr.size() - 1, gap);
        end
        hdr.delete();
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
    endtask

    task automatic send_text(string s);
        push_str(s);
        send_header();
    endtask

    task automatic push_blanks(int n);
        repeat (n) hdr.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
    endtask

    task automatic push_digits(int n);
        repeat (n) hdr.push_back(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    task automatic push_number();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: push_str("9223372036854775807");
                    1: push_str("9223372036854775808");
                    2: push_str("9223372036854775806");
                    3: push_str("922337203685477580");
                    4: push_str("99999999999999999999");
                    default: push_str("0");
                endcase
            end
            1: push_digits($urandom_range(19, 22));
            default: begin
                if ($urandom_range(0, 9) == 0) push_digits(0);
                if ($urandom_range(0, 9) == 0) push_str("00");
                push_digits($urandom_range(1, 6));
            end
        endcase
    endtask

    task automatic push_sign();
        case ($urandom_range(0, 19))
            0: hdr.push_back("+");
            1: hdr.push_back("-");
            2: hdr.push_back(8'(8'd10 + $urandom_range(0, 3)));
            default: begin
            end
        endcase
    endtask

    task automatic build_random();
        int kind;
        int pos;
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
            push_str("bytes=");
            push_blanks($urandom_range(0, 2));
            push_sign();
            if ($urandom_range(0, 9) != 0) push_number();
            else if ($urandom_range(0, 1)) hdr.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) push_blanks(1);
            if ($urandom_range(0, 19) != 0) hdr.push_back("-");
            push_sign();
            if ($urandom_range(0, 4) != 0) push_number();
            if ($urandom_range(0, 6) == 0) begin
                hdr.push_back(",");
                push_number();
                hdr.push_back("-");
                push_number();
            end
            if ($urandom_range(0, 19) == 0) begin
                pos = $urandom_range(0, hdr.size());
                hdr.insert(pos, 8'h00);
            end
        end else if (kind < 87) begin
            push_str("bytes=");
            if ($urandom_range(0, 1)) begin
                hdr[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
            end else begin
                repeat ($urandom_range(1, 6)) void'(hdr.pop_back());
            end
            repeat ($urandom_range(0, 4)) hdr.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1)) push_str("bytes=");
            repeat ($urandom_range(1, 12)) hdr.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver side, with one long hold-off to back the block up
    initial begin
        int  n;
        int  mode;
        int  taken;
        bit  pressed;
        mode = 1;
        taken = 0;
        pressed = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressed && taken == 25) begin
                pressed = 1'b1;
                press_hold = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                press_hold = 1'b0;
            end else begin
                if ($urandom_range(0, 15) == 0) mode = $urandom_range(0, 2);
                if (mode == 0) n = 0;
                else if (mode == 1) n = $urandom_range(0, 18);
                else n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
                if (n > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed headers
        send_text("bytes=0-0");
        send_text("bytes=-5");
        send_text("bytes=");
        send_text("byt");
        send_text("Bytes=1-2");
        send_text("bytes=7");
        send_text("bytes= \t12-34");
        send_text("bytes=x-5");
        send_text("bytes=9-3");
        send_text("bytes=5-");
        send_text("bytes=9223372036854775807-9223372036854775807");
        send_text("bytes=99999999999999999999-");
        send_text("bytes=1-2,5-9");
        push_str("bytes=");
        hdr.push_back(8'h0b);
        push_str("+3--4");
        send_header();
        push_str("bytes=4-");
        hdr.push_back(8'h00);
        push_str("9");
        send_header();
        push_str("bytes=");
        hdr.push_back(8'h00);
        push_str("1-2");
        send_header();
        hdr.push_back(8'hff);
        send_header();

        while (chars_sent < CHAR_TARGET) begin
            build_random();
            send_header();
        end
        i_s_tvalid <= 1'b0;

        while (sb.range_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> byte_range_header_parser_top.f
+incdir+rtl/core
rtl/core/brhp_pkg.sv
rtl/core/brhp_num_feed.sv
rtl/core/byte_range_header_parser_top.sv
rtl/core/brhp_checker.sv
verif/byte_range_header_parser_top_tb.sv
